FILE: hdl/csbf_pkg.sv
// Shared constants and codes for the counting semaphore bank with wait queues.
`default_nettype none
package csbf_pkg;
  localparam int NUM_SEMS_DEF    = 16;
  localparam int QUEUE_DEPTH_DEF = 64;

  localparam int MODE_W    = 2;
  localparam int ID_W      = 6;
  localparam int IVAL_W    = 12;
  localparam int REQ_W     = 6;
  localparam int STATUS_W  = 3;
  localparam int CNT_W     = 13;

  localparam logic signed [CNT_W-1:0] COUNT_MAX = 13'sd4095;

  localparam logic [MODE_W-1:0] MODE_INIT    = 2'd0;
  localparam logic [MODE_W-1:0] MODE_ACQUIRE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_RELEASE = 2'd2;
  localparam logic [MODE_W-1:0] MODE_UNUSED  = 2'd3;

  localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
  localparam logic [STATUS_W-1:0] ST_BLOCKED = 3'd1;
  localparam logic [STATUS_W-1:0] ST_BAD_ID  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_ALREADY = 3'd3;
  localparam logic [STATUS_W-1:0] ST_FULL    = 3'd4;
endpackage
`default_nettype wire

FILE: hdl/csbf_ram.sv
// Generic simple dual-port RAM with a registered read.
`default_nettype none
module csbf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end
endmodule
`default_nettype wire

FILE: hdl/counting_semaphore_bank_fifo_unit.sv
// Top level of the counting semaphore bank with a FIFO wait queue per semaphore.
//
//   Channel  Ports                                           Handshake
//   input    in_mode in_sem_id in_init_value in_requester    start, busy
//   result   out_status out_woken_valid out_woken_requester  out_strobe
//            out_count_after
//
// An item reads the semaphore's state memory on acceptance and updates it in S_UPD;
// a release that wakes a waiter also reads the wait ring memory there and takes the
// woken requester in S_WAKE. The result strobe rises the cycle after the last state.
// Reset clears state, strobe and initialized flags; the memories need no clearing
// pass. The receiver cannot stall, so busy depends on the work in hand alone.
`default_nettype none
module counting_semaphore_bank_fifo_unit
  import csbf_pkg::*;
#(
  parameter int NUM_SEMS    = NUM_SEMS_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  output logic                     busy,
  input  wire logic [MODE_W-1:0]   in_mode,
  input  wire logic [ID_W-1:0]     in_sem_id,
  input  wire logic [IVAL_W-1:0]   in_init_value,
  input  wire logic [REQ_W-1:0]    in_requester,
  output logic                     out_strobe,
  output logic [STATUS_W-1:0]      out_status,
  output logic                     out_woken_valid,
  output logic [REQ_W-1:0]         out_woken_requester,
  output logic signed [CNT_W-1:0]  out_count_after
);
  localparam int SID_W   = (NUM_SEMS > 1) ? $clog2(NUM_SEMS) : 1;
  localparam int SLOT_W  = $clog2(QUEUE_DEPTH);
  localparam int FILL_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int SW      = CNT_W + 2 * SLOT_W + FILL_W;
  localparam int RING_AW = SID_W + SLOT_W;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_UPD  = 2'd1;
  localparam logic [1:0] S_WAKE = 2'd2;

  logic [1:0]              state_r, state_nxt;
  logic [NUM_SEMS-1:0]     ready_r, ready_nxt;
  logic [MODE_W-1:0]       mode_r;
  logic [SID_W-1:0]        sid_r;
  logic [IVAL_W-1:0]       ival_r;
  logic [REQ_W-1:0]        req_r;
  logic                    bad_r;

  logic                    strobe_r, strobe_nxt;
  logic [STATUS_W-1:0]     status_r, status_nxt;
  logic                    wv_r, wv_nxt;
  logic [REQ_W-1:0]        wid_r, wid_nxt;
  logic signed [CNT_W-1:0] cnt_r, cnt_nxt;

  logic                    accept;
  logic                    st_we;
  logic [SW-1:0]           st_wdata, st_rdata;
  logic                    ring_we, ring_re;
  logic [RING_AW-1:0]      ring_waddr, ring_raddr;
  logic [REQ_W-1:0]        ring_rdata;

  logic signed [CNT_W-1:0] rd_cnt, new_cnt;
  logic [SLOT_W-1:0]       rd_head, rd_tail, new_head, new_tail;
  logic [FILL_W-1:0]       rd_fill, new_fill;
  logic                    sem_ready;

  assign accept = start && !busy;
  assign busy   = (state_r != S_IDLE);

  assign {rd_cnt, rd_head, rd_tail, rd_fill} = st_rdata;
  assign sem_ready = ready_r[sid_r];
  assign st_wdata  = {new_cnt, new_head, new_tail, new_fill};

  csbf_ram #(
    .WIDTH (SW),
    .DEPTH (2 ** SID_W)
  ) u_state_ram (
    .clk     (clk),
    .wr_en   (st_we),
    .wr_addr (sid_r),
    .wr_data (st_wdata),
    .rd_en   (accept),
    .rd_addr (in_sem_id[SID_W-1:0]),
    .rd_data (st_rdata)
  );

  csbf_ram #(
    .WIDTH (REQ_W),
    .DEPTH (2 ** RING_AW)
  ) u_ring_ram (
    .clk     (clk),
    .wr_en   (ring_we),
    .wr_addr (ring_waddr),
    .wr_data (req_r),
    .rd_en   (ring_re),
    .rd_addr (ring_raddr),
    .rd_data (ring_rdata)
  );

  assign ring_waddr = {sid_r, rd_tail};
  assign ring_raddr = {sid_r, rd_head};

  always_comb begin
    state_nxt  = state_r;
    ready_nxt  = ready_r;
    strobe_nxt = 1'b0;
    status_nxt = status_r;
    wv_nxt     = wv_r;
    wid_nxt    = wid_r;
    cnt_nxt    = cnt_r;
    st_we      = 1'b0;
    ring_we    = 1'b0;
    ring_re    = 1'b0;
    new_cnt    = rd_cnt;
    new_head   = rd_head;
    new_tail   = rd_tail;
    new_fill   = rd_fill;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_UPD;
        end
      end
      S_UPD: begin
        state_nxt  = S_IDLE;
        strobe_nxt = 1'b1;
        wv_nxt     = 1'b0;
        wid_nxt    = '0;
        status_nxt = ST_OK;
        cnt_nxt    = '0;
        if (bad_r) begin
          status_nxt = ST_BAD_ID;
        end else if (mode_r == MODE_INIT) begin
          if (sem_ready) begin
            status_nxt = ST_ALREADY;
            cnt_nxt    = rd_cnt;
          end else begin
            new_cnt   = signed'(CNT_W'(ival_r));
            new_head  = '0;
            new_tail  = '0;
            new_fill  = '0;
            st_we     = 1'b1;
            ready_nxt[sid_r] = 1'b1;
            cnt_nxt   = new_cnt;
          end
        end else if (!sem_ready) begin
          status_nxt = ST_BAD_ID;
        end else if (mode_r == MODE_ACQUIRE) begin
          if (rd_cnt <= 0) begin
            if (rd_fill >= FILL_W'(QUEUE_DEPTH)) begin
              status_nxt = ST_FULL;
              cnt_nxt    = rd_cnt;
            end else begin
              ring_we    = 1'b1;
              new_tail   = (rd_tail == SLOT_W'(QUEUE_DEPTH - 1)) ? '0 : rd_tail + 1'b1;
              new_fill   = rd_fill + 1'b1;
              new_cnt    = rd_cnt - CNT_W'(1);
              st_we      = 1'b1;
              status_nxt = ST_BLOCKED;
              cnt_nxt    = new_cnt;
            end
          end else begin
            new_cnt = rd_cnt - CNT_W'(1);
            st_we   = 1'b1;
            cnt_nxt = new_cnt;
          end
        end else begin
          new_cnt = (rd_cnt < COUNT_MAX) ? rd_cnt + CNT_W'(1) : rd_cnt;
          st_we   = 1'b1;
          cnt_nxt = new_cnt;
          if (rd_fill != '0) begin
            ring_re    = 1'b1;
            new_head   = (rd_head == SLOT_W'(QUEUE_DEPTH - 1)) ? '0 : rd_head + 1'b1;
            new_fill   = rd_fill - 1'b1;
            strobe_nxt = 1'b0;
            state_nxt  = S_WAKE;
          end
        end
      end
      S_WAKE: begin
        state_nxt  = S_IDLE;
        strobe_nxt = 1'b1;
        wv_nxt     = 1'b1;
        wid_nxt    = ring_rdata;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      ready_r  <= '0;
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      ready_r  <= ready_nxt;
      strobe_r <= strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      mode_r <= in_mode;
      sid_r  <= in_sem_id[SID_W-1:0];
      ival_r <= in_init_value;
      req_r  <= in_requester;
      bad_r  <= (in_mode == MODE_UNUSED) || ({1'b0, in_sem_id} >= (ID_W + 1)'(NUM_SEMS));
    end
    status_r <= status_nxt;
    wv_r     <= wv_nxt;
    wid_r    <= wid_nxt;
    cnt_r    <= cnt_nxt;
  end

  assign out_strobe          = strobe_r;
  assign out_status          = status_r;
  assign out_woken_valid     = wv_r;
  assign out_woken_requester = wid_r;
  assign out_count_after     = cnt_r;
endmodule
`default_nettype wire
